### rtl/sparse_dot_product_merge_unit_macros.svh
// Assertion macros used by the checker file of the sparse dot product unit.
`ifndef SPARSE_DOT_PRODUCT_MERGE_UNIT_MACROS_SVH
`define SPARSE_DOT_PRODUCT_MERGE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SDPM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdpm assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SDPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdpm assertion failed");

`endif

### rtl/sdpm_pkg.sv
// Shared types and constants of the sparse dot product merge unit.
`default_nettype none

package sdpm_pkg;

    localparam int MAX_ENTRIES_DEF = 256;
    localparam int IDX_W = 16;
    localparam int VAL_W = 16;
    localparam int PROD_W = 2 * VAL_W;
    localparam int SUM_W = 48;

    typedef enum logic [1:0] {
        CMD_FIRST   = 2'd0,
        CMD_SECOND  = 2'd1,
        CMD_COMPUTE = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    // Control from the merge sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic clear;   // start a new sum
        logic step;    // read data of both lists is valid this cycle
        logic match;   // both indices are equal
    } mac_ctrl_t;

endpackage

`default_nettype wire

### rtl/sdpm_if.sv
// Valid/ready channel interfaces for input items and result items.
`default_nettype none

interface sdpm_in_if;
    logic                valid;
    logic                ready;
    logic [1:0]          cmd;
    logic [15:0]         entry_index;
    logic signed [15:0]  entry_value;

    modport source (output valid, cmd, entry_index, entry_value, input ready);
    modport sink (input valid, cmd, entry_index, entry_value, output ready);
endinterface

interface sdpm_out_if;
    logic                valid;
    logic                ready;
    logic signed [47:0]  dot_sum;
    logic                overflow;

    modport source (output valid, dot_sum, overflow, input ready);
    modport sink (input valid, dot_sum, overflow, output ready);
endinterface

`default_nettype wire

### rtl/sdpm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module sdpm_ram
    import sdpm_pkg::*;
#(
    parameter int WIDTH = IDX_W + VAL_W,
    parameter int DEPTH = MAX_ENTRIES_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/sdpm_mac.sv
// Multiply-accumulate unit: registered product, then 48-bit accumulation.
`default_nettype none

module sdpm_mac
    import sdpm_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire mac_ctrl_t                ctrl,
    input  wire logic signed [VAL_W-1:0]  val_a,
    input  wire logic signed [VAL_W-1:0]  val_b,
    output logic signed [SUM_W-1:0]       acc
);

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_vld_reg;
    logic signed [SUM_W-1:0]  acc_reg;
    logic signed [SUM_W-1:0]  acc_next;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (prod_vld_reg)
        begin
            acc_next = acc_reg + SUM_W'(prod_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= ctrl.step && ctrl.match && !ctrl.clear;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= val_a * val_b;
        acc_reg  <= acc_next;
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

### rtl/sparse_dot_product_merge_unit.sv
// Top level of the sparse dot product unit: list loading, merge sequencer, result register.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+------------------------------------------
//  in_ch    | in  | valid / ready | cmd[1:0], entry_index[15:0], entry_value[15:0]
//  out_ch   | out | valid / ready | dot_sum[47:0] (Q31.16), overflow
//
//  A load item (append to first or second list) is accepted in idle; a full list drops it.
//  A compute item runs at most first_count + second_count merge steps; each step is
//  a read of both list RAMs (registered read data) followed by the index compare.
//  The result waits in an output register; loads are taken while it waits, and a later
//  compute holds in its final cycle until that register frees up.
//  Reset clears counts, overflow flag and control; list RAMs need no clearing.
`default_nettype none

module sparse_dot_product_merge_unit
    import sdpm_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    sdpm_in_if.sink     in_ch,
    sdpm_out_if.source  out_ch
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int DW = IDX_W + VAL_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RD   = 4'b0010,
        ST_CMP  = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0] cnt_a_reg, cnt_a_next;
    logic [CW-1:0] cnt_b_reg, cnt_b_next;
    logic [CW-1:0] ptr_a_reg, ptr_a_next;
    logic [CW-1:0] ptr_b_reg, ptr_b_next;
    logic          ovf_reg, ovf_next;

    logic                    out_vld_reg, out_vld_next;
    logic signed [SUM_W-1:0] out_sum_reg;
    logic                    out_ovf_reg;
    logic                    out_load;

    logic          in_acc;
    cmd_t          cmd;
    logic          wr_a, wr_b;
    logic          rd_en;
    logic [DW-1:0] wr_data;
    logic [DW-1:0] rd_a, rd_b;
    logic          idx_eq, idx_lt;
    logic          more;

    mac_ctrl_t               mac_ctrl;
    logic signed [SUM_W-1:0] acc;

    assign cmd     = cmd_t'(in_ch.cmd);
    assign in_acc  = in_ch.valid && in_ch.ready;
    assign wr_data = {in_ch.entry_index, in_ch.entry_value};

    // Appends land at the current count; drop them once the list is full.
    assign wr_a = in_acc && (cmd == CMD_FIRST) && (cnt_a_reg < CW'(MAX_ENTRIES));
    assign wr_b = in_acc && (cmd == CMD_SECOND) && (cnt_b_reg < CW'(MAX_ENTRIES));

    // Writes happen only in idle and reads only during the merge: no overlap to forward.
    assign rd_en  = (state_reg == ST_RD);
    assign more   = (ptr_a_reg < cnt_a_reg) && (ptr_b_reg < cnt_b_reg);
    assign idx_eq = (rd_a[DW-1:VAL_W] == rd_b[DW-1:VAL_W]);
    assign idx_lt = (rd_a[DW-1:VAL_W] < rd_b[DW-1:VAL_W]);

    assign out_load = (state_reg == ST_FIN) && (!out_vld_reg || out_ch.ready);

    always_comb
    begin
        state_next   = state_reg;
        cnt_a_next   = cnt_a_reg;
        cnt_b_next   = cnt_b_reg;
        ptr_a_next   = ptr_a_reg;
        ptr_b_next   = ptr_b_reg;
        ovf_next     = ovf_reg;
        out_vld_next = out_vld_reg;
        mac_ctrl     = '0;

        if (out_vld_reg && out_ch.ready)
        begin
            out_vld_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    case (cmd)
                        CMD_FIRST:
                        begin
                            if (wr_a)
                            begin
                                cnt_a_next = cnt_a_reg + 1'b1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        CMD_SECOND:
                        begin
                            if (wr_b)
                            begin
                                cnt_b_next = cnt_b_reg + 1'b1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        CMD_COMPUTE:
                        begin
                            ptr_a_next     = '0;
                            ptr_b_next     = '0;
                            mac_ctrl.clear = 1'b1;
                            state_next     = ST_RD;
                        end
                        default:
                        begin
                            // unused command: drop it
                        end
                    endcase
                end
            end
            ST_RD:
            begin
                // Read both heads, or finish once either list runs out.
                state_next = more ? ST_CMP : ST_FIN;
            end
            ST_CMP:
            begin
                mac_ctrl.step  = 1'b1;
                mac_ctrl.match = idx_eq;
                if (idx_eq || idx_lt)
                begin
                    ptr_a_next = ptr_a_reg + 1'b1;
                end
                if (idx_eq || !idx_lt)
                begin
                    ptr_b_next = ptr_b_reg + 1'b1;
                end
                state_next = ST_RD;
            end
            ST_FIN:
            begin
                // Hold until the result register is free, then emit and clear the lists.
                if (out_load)
                begin
                    out_vld_next = 1'b1;
                    cnt_a_next   = '0;
                    cnt_b_next   = '0;
                    ovf_next     = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_a_reg   <= '0;
            cnt_b_reg   <= '0;
            ptr_a_reg   <= '0;
            ptr_b_reg   <= '0;
            ovf_reg     <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_a_reg   <= cnt_a_next;
            cnt_b_reg   <= cnt_b_next;
            ptr_a_reg   <= ptr_a_next;
            ptr_b_reg   <= ptr_b_next;
            ovf_reg     <= ovf_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_sum_reg <= acc;
            out_ovf_reg <= ovf_reg;
        end
    end

    sdpm_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_ENTRIES)
    ) u_ram_a (
        .clk     (clk),
        .wr_en   (wr_a),
        .wr_addr (cnt_a_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (ptr_a_reg[AW-1:0]),
        .rd_data (rd_a)
    );

    sdpm_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_ENTRIES)
    ) u_ram_b (
        .clk     (clk),
        .wr_en   (wr_b),
        .wr_addr (cnt_b_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (ptr_b_reg[AW-1:0]),
        .rd_data (rd_b)
    );

    sdpm_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .val_a ($signed(rd_a[VAL_W-1:0])),
        .val_b ($signed(rd_b[VAL_W-1:0])),
        .acc   (acc)
    );

    assign in_ch.ready     = (state_reg == ST_IDLE);
    assign out_ch.valid    = out_vld_reg;
    assign out_ch.dot_sum  = out_sum_reg;
    assign out_ch.overflow = out_ovf_reg;

endmodule

`default_nettype wire

### rtl/sdpm_checker.sv
// Port-level checker for the sparse dot product unit and its bind to the top level.
`default_nettype none
`include "sparse_dot_product_merge_unit_macros.svh"

module sdpm_checker
    import sdpm_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic [1:0]        in_cmd,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [SUM_W-1:0]  out_dot_sum,
    input wire logic              out_overflow
);

    // A stalled result stays and keeps its payload.
    `SDPM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `SDPM_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_dot_sum) && $stable(out_overflow))
    // A compute item closes the input side while the merge runs.
    `SDPM_ASSERT_NEXT(a_compute_busy, clk, rst_n, in_valid && in_ready && (in_cmd == CMD_COMPUTE), !in_ready)
    // A new result appears only at the end of a merge, never straight out of idle.
    `SDPM_ASSERT_NOW(a_result_after_merge, clk, rst_n, $rose(out_valid), !$past(in_ready))

endmodule

bind sparse_dot_product_merge_unit sdpm_checker u_sdpm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_cmd       (in_ch.cmd),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_dot_sum  (out_ch.dot_sum),
    .out_overflow (out_ch.overflow)
);

`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench for the sparse dot product merge unit: random load/compute items.
module tb_top;
    import sdpm_pkg::*;

    localparam int LIST_DEPTH   = MAX_ENTRIES_DEF;
    localparam int RANDOM_ITEMS = 1200;
    // Longest quiet stretch: a merge over two full lists, plus stalls on both sides.
    localparam int STALL_LIMIT  = 8 * (4 * LIST_DEPTH + 16);
    localparam int SETTLE_CYCLES = 32;

    typedef struct {
        cmd_t        cmd;
        logic [15:0] idx;
        logic [15:0] val;
        bit          wait_drain;   // hold this item until every sum has come back
    } cmd_item_t;

    typedef struct {
        logic [15:0] idx;
        logic [15:0] val;
    } entry_t;

    typedef struct {
        logic signed [47:0] dot_sum;
        logic               overflow;
    } dot_result_t;

    logic clk = 1'b0;
    logic rst_n;

    sdpm_in_if  in_ch ();
    sdpm_out_if out_ch ();

    sparse_dot_product_merge_unit #(
        .MAX_ENTRIES (LIST_DEPTH)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: a private copy of both lists and the drop flag.
    // ------------------------------------------------------------------
    logic [15:0] first_idx_mem  [LIST_DEPTH];
    logic [15:0] first_val_mem  [LIST_DEPTH];
    logic [15:0] second_idx_mem [LIST_DEPTH];
    logic [15:0] second_val_mem [LIST_DEPTH];
    int          first_fill  = 0;
    int          second_fill = 0;
    bit          drop_flag   = 1'b0;

    dot_result_t expected_dots [$];
    cmd_item_t   pending_items [$];
    entry_t      first_stage   [$];
    entry_t      second_stage  [$];

    int queued_count   = 0;   // items that the block acts on (unused command excluded)
    int item_total     = 0;
    int accepted_count = 0;
    int error_count    = 0;
    int idle_cycles    = 0;

    bit in_taken   = 1'b0;
    bit out_taken  = 1'b0;
    int send_gap   = 0;
    bit send_burst = 1'b0;
    int recv_stall = 0;
    bit recv_burst = 1'b0;

    // Walk both lists like a merge; sum the products on equal indices, then clear.
    function automatic dot_result_t merge_dot();
        dot_result_t r;
        int          a;
        int          b;
        longint      acc;
        a = 0;
        b = 0;
        acc = 0;
        while (a < first_fill && b < second_fill) begin
            if (first_idx_mem[a] == second_idx_mem[b]) begin
                acc += longint'($signed(first_val_mem[a])) * longint'($signed(second_val_mem[b]));
                a++;
                b++;
            end
            else if (first_idx_mem[a] < second_idx_mem[b])
                a++;
            else
                b++;
        end
        r.dot_sum  = acc[47:0];
        r.overflow = drop_flag;
        first_fill  = 0;
        second_fill = 0;
        drop_flag   = 1'b0;
        return r;
    endfunction

    // Update the predicted lists for one accepted item; queue a sum on compute.
    task automatic apply_command(cmd_t c, logic [15:0] idx, logic [15:0] val);
        case (c)
            CMD_FIRST:
                if (first_fill >= LIST_DEPTH)
                    drop_flag = 1'b1;
                else
                begin
                    first_idx_mem[first_fill] = idx;
                    first_val_mem[first_fill] = val;
                    first_fill++;
                end
            CMD_SECOND:
                if (second_fill >= LIST_DEPTH)
                    drop_flag = 1'b1;
                else
                begin
                    second_idx_mem[second_fill] = idx;
                    second_val_mem[second_fill] = val;
                    second_fill++;
                end
            CMD_COMPUTE:
                expected_dots.push_back(merge_dot());
            default:
                ;   // unused command: no state change
        endcase
    endtask

    task automatic note_error(string msg);
        error_count++;
        if (error_count <= 10)
            $display("%s", msg);
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_cmd(cmd_t c, logic [15:0] idx, logic [15:0] val, bit drain);
        cmd_item_t it;
        it.cmd = c;
        it.idx = idx;
        it.val = val;
        it.wait_drain = drain;
        pending_items.push_back(it);
        if (c != CMD_NONE)
            queued_count++;
    endtask

    // Favor the range ends of Q7.8; otherwise any 16-bit pattern.
    function automatic logic [15:0] draw_value();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Interleave the staged lists at random (each keeps its own order), then compute.
    task automatic flush_lists(bit drain);
        entry_t e;
        bit     pick_second;
        bit     mark;
        mark = drain;
        while (first_stage.size() + second_stage.size() != 0) begin
            if (first_stage.size() == 0)
                pick_second = 1'b1;
            else if (second_stage.size() == 0)
                pick_second = 1'b0;
            else
                pick_second = 1'($urandom_range(0, 1));
            if (pick_second)
            begin
                e = second_stage.pop_front();
                push_cmd(CMD_SECOND, e.idx, e.val, mark);
            end
            else
            begin
                e = first_stage.pop_front();
                push_cmd(CMD_FIRST, e.idx, e.val, mark);
            end
            mark = 1'b0;
            // Sprinkle in an unused command now and then; it must change nothing.
            if ($urandom_range(0, 39) == 0)
                push_cmd(CMD_NONE, 16'($urandom), 16'($urandom), 1'b0);
        end
        push_cmd(CMD_COMPUTE, 16'($urandom), 16'($urandom), mark);
    endtask

    // Fill a list past capacity. With second_over the first list is exactly full,
    // the second overflows, and every index matches with the most negative value,
    // which drives the sum to its largest magnitude.
    task automatic add_full_run(bit second_over);
        entry_t e;
        int     stride;
        stride = $urandom_range(1, 250);
        for (int i = 0; i < LIST_DEPTH + 3; i++) begin
            e.idx = 16'(i * stride);
            if (second_over)
            begin
                e.val = 16'h8000;
                if (i < LIST_DEPTH)
                    first_stage.push_back(e);
                second_stage.push_back(e);
            end
            else
            begin
                e.val = draw_value();
                first_stage.push_back(e);
                // Also match one index that was dropped from the first list.
                if (i % 37 == 0 || i == LIST_DEPTH + 1)
                begin
                    e.val = draw_value();
                    second_stage.push_back(e);
                end
            end
        end
        flush_lists(1'b0);
    endtask

    // ------------------------------------------------------------------
    // Sender: present pending items, hold until accepted, then idle a while.
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        cmd_item_t item;
        if (rst_n !== 1'b1)
            in_ch.valid <= 1'b0;
        else if (in_ch.valid === 1'b1 && !in_taken)
            ;   // hold the item until the block takes it
        else if (send_gap != 0)
        begin
            in_ch.valid <= 1'b0;
            send_gap <= send_gap - 1;
        end
        else if (pending_items.size() != 0 &&
                 !(pending_items[0].wait_drain && expected_dots.size() != 0))
        begin
            item = pending_items.pop_front();
            in_ch.cmd         <= item.cmd;
            in_ch.entry_index <= item.idx;
            in_ch.entry_value <= item.val;
            in_ch.valid       <= 1'b1;
            send_gap <= send_burst ? 0 : $urandom_range(0, 7);
            if ($urandom_range(0, 15) == 0)
                send_burst <= !send_burst;
        end
        else
            in_ch.valid <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Receiver: after each result, stall for a drawn number of cycles that
    // only run down while a result is offered, so the stall lands on it.
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (out_taken)
        begin
            recv_stall = recv_burst ? 0 : $urandom_range(0, 7);
            if ($urandom_range(0, 15) == 0)
                recv_burst = !recv_burst;
        end
        if (rst_n !== 1'b1)
            out_ch.ready <= 1'b0;
        else
        begin
            out_ch.ready <= (recv_stall == 0);
            if (recv_stall != 0 && out_ch.valid === 1'b1)
                recv_stall--;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on accepted items, check accepted results in order,
    // and end the run if nothing moves for too long.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        dot_result_t want;
        bit          in_fire;
        bit          out_fire;
        in_fire  = rst_n === 1'b1 && in_ch.valid === 1'b1 && in_ch.ready === 1'b1;
        out_fire = rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1;
        in_taken  <= in_fire;
        out_taken <= out_fire;

        if (out_fire)
        begin
            if (expected_dots.size() == 0)
                note_error($sformatf("unexpected sum: dot_sum=%0d overflow=%0b",
                                     out_ch.dot_sum, out_ch.overflow));
            else
            begin
                want = expected_dots.pop_front();
                if (out_ch.dot_sum !== want.dot_sum || out_ch.overflow !== want.overflow)
                    note_error($sformatf(
                        "sum mismatch: expected dot_sum=%0d overflow=%0b, got dot_sum=%0d overflow=%0b",
                        want.dot_sum, want.overflow, out_ch.dot_sum, out_ch.overflow));
            end
        end

        if (in_fire)
        begin
            apply_command(cmd_t'(in_ch.cmd), in_ch.entry_index, in_ch.entry_value);
            accepted_count++;
        end

        if (in_fire || out_fire || rst_n !== 1'b1)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("[sparse_dot_product_merge_unit] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Build the whole item list, release reset, then wait for the drain.
    // ------------------------------------------------------------------
    initial begin
        entry_t e;
        int     base_count;
        int     seq_num;
        int     ncand;
        int     stride;
        int     start;
        int     n;
        int     pick;

        rst_n = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.cmd         = CMD_NONE;
        in_ch.entry_index = '0;
        in_ch.entry_value = '0;
        out_ch.ready      = 1'b0;
        recv_stall = $urandom_range(0, 7);

        // Directed: empty lists, range ends, one-sided lists, unsorted order,
        // unused command, back-to-back computes.
        push_cmd(CMD_COMPUTE, 16'hFFFF, 16'hFFFF, 1'b0);   // both lists empty
        push_cmd(CMD_NONE,    16'hFFFF, 16'h7FFF, 1'b0);
        push_cmd(CMD_FIRST,   16'h0000, 16'h7FFF, 1'b0);
        push_cmd(CMD_FIRST,   16'h8000, 16'h8000, 1'b0);
        push_cmd(CMD_FIRST,   16'hFFFF, 16'h8000, 1'b0);
        push_cmd(CMD_SECOND,  16'h0000, 16'h7FFF, 1'b0);
        push_cmd(CMD_SECOND,  16'h7FFF, 16'h1234, 1'b0);
        push_cmd(CMD_SECOND,  16'hFFFF, 16'h8000, 1'b0);
        push_cmd(CMD_COMPUTE, 16'h0000, 16'h0000, 1'b0);
        push_cmd(CMD_FIRST,   16'h0005, 16'h0100, 1'b0);
        push_cmd(CMD_COMPUTE, 16'h0005, 16'h0100, 1'b0);   // second list empty
        push_cmd(CMD_SECOND,  16'h0007, 16'h0100, 1'b0);
        push_cmd(CMD_COMPUTE, 16'h0007, 16'h0100, 1'b0);   // first list empty
        push_cmd(CMD_FIRST,   16'h0009, 16'h0001, 1'b0);   // unsorted lists
        push_cmd(CMD_FIRST,   16'h0003, 16'h0200, 1'b0);
        push_cmd(CMD_SECOND,  16'h0003, 16'hFF00, 1'b0);
        push_cmd(CMD_SECOND,  16'h0009, 16'h0300, 1'b0);
        push_cmd(CMD_NONE,    16'h0003, 16'h0000, 1'b0);
        push_cmd(CMD_COMPUTE, 16'h0000, 16'h0000, 1'b0);
        push_cmd(CMD_COMPUTE, 16'hFFFF, 16'h8000, 1'b0);   // right behind the last one
        push_cmd(CMD_FIRST,   16'h1111, 16'hFFFF, 1'b1);   // pause until all sums are back
        push_cmd(CMD_SECOND,  16'h1111, 16'h0001, 1'b0);
        push_cmd(CMD_COMPUTE, 16'h0000, 16'h0000, 1'b0);

        // Random: mostly sorted list pairs sharing some indices, the rest noise.
        // The two over-capacity runs count toward the item budget.
        base_count = queued_count;
        seq_num = 0;
        while (queued_count - base_count < RANDOM_ITEMS) begin
            if (seq_num == 5 || seq_num == 25)
                add_full_run(seq_num == 25);
            pick = $urandom_range(0, 99);
            if (pick < 85)
            begin
                ncand = $urandom_range(0, 16);
                stride = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4000)
                                                     : $urandom_range(1, 4);
                start = $urandom_range(0, 65535 - ncand * stride);
                for (int c = 0; c < ncand; c++) begin
                    e.idx = 16'(start + c * stride);
                    case ($urandom_range(0, 3))
                        0: begin
                            e.val = draw_value();
                            first_stage.push_back(e);
                        end
                        1: begin
                            e.val = draw_value();
                            second_stage.push_back(e);
                        end
                        default: begin
                            e.val = draw_value();
                            first_stage.push_back(e);
                            e.val = draw_value();
                            second_stage.push_back(e);
                        end
                    endcase
                end
                flush_lists($urandom_range(0, 9) == 0);
            end
            else
            begin
                // Broken sequence: any command, unsorted and often repeated indices.
                n = $urandom_range(1, 10);
                for (int k = 0; k < n; k++)
                    push_cmd(cmd_t'($urandom_range(0, 3)),
                             ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 7))
                                                         : 16'($urandom),
                             16'($urandom), 1'b0);
                if ($urandom_range(0, 3) != 0)
                    push_cmd(CMD_COMPUTE, 16'($urandom), 16'($urandom), 1'b0);
            end
            seq_num++;
        end
        item_total = pending_items.size();

        // Hold reset, then release it away from the sampling edge.
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (accepted_count != item_total)
            @(posedge clk);
        while (expected_dots.size() != 0)
            @(posedge clk);
        // Watch a little longer for stray sums.
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("[sparse_dot_product_merge_unit] OK");
        else
            $display("[sparse_dot_product_merge_unit] ERROR");
        $finish;
    end

endmodule
